// File: sv/bpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press qualifier package
// Shared widths, codes, defaults and the configuration record.
// ----------------------------------------------------------------------------
package bpq_pkg;

   localparam int COUNT_WIDTH_DEFAULT     = 16;
   localparam int REPEAT_STEP_ONE_DEFAULT = 10;
   localparam int REPEAT_STEP_TWO_DEFAULT = 20;

   localparam int CFG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int MODE_WIDTH      = 2;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int RSP_DATA_WIDTH  = 8;

   // Item kinds carried in req_tuser.
   localparam logic [MODE_WIDTH-1:0] MODE_TICK       = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_READ_SHORT = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_READ_LONG  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AUTOREPEAT_ENABLE      = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG_PRESS_ENABLE      = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS         = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG_TICKS             = 8'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT_INTERVAL_FIRST  = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT_INTERVAL_SECOND = 8'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT_INTERVAL_THIRD  = 8'd6;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RESET         = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_TICKS_RESET             = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_FIRST_RESET  = 16'd500;
   localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_SECOND_RESET = 16'd200;
   localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_THIRD_RESET  = 16'd50;

   typedef struct packed {
      logic                 autorepeat_enable;
      logic                 long_press_enable;
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] long_ticks;
      logic [CFG_WIDTH-1:0] repeat_interval_first;
      logic [CFG_WIDTH-1:0] repeat_interval_second;
      logic [CFG_WIDTH-1:0] repeat_interval_third;
   } cfg_type;

endpackage

// File: sv/bpq_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press qualifier configuration registers
// Holds the seven control registers written through the csr channel.
// ----------------------------------------------------------------------------
module bpq_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [bpq_pkg::CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [bpq_pkg::CSR_DATA_WIDTH-1:0]  wr_data,
   output bpq_pkg::cfg_type                    cfg
);

   bpq_pkg::cfg_type cfg_ff;
   bpq_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            bpq_pkg::REG_AUTOREPEAT_ENABLE: cfg_in.autorepeat_enable = wr_data[0];
            bpq_pkg::REG_LONG_PRESS_ENABLE: cfg_in.long_press_enable = wr_data[0];
            bpq_pkg::REG_DEBOUNCE_TICKS:
               cfg_in.debounce_ticks = wr_data[bpq_pkg::CFG_WIDTH-1:0];
            bpq_pkg::REG_LONG_TICKS:
               cfg_in.long_ticks = wr_data[bpq_pkg::CFG_WIDTH-1:0];
            bpq_pkg::REG_REPEAT_INTERVAL_FIRST:
               cfg_in.repeat_interval_first = wr_data[bpq_pkg::CFG_WIDTH-1:0];
            bpq_pkg::REG_REPEAT_INTERVAL_SECOND:
               cfg_in.repeat_interval_second = wr_data[bpq_pkg::CFG_WIDTH-1:0];
            bpq_pkg::REG_REPEAT_INTERVAL_THIRD:
               cfg_in.repeat_interval_third = wr_data[bpq_pkg::CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.autorepeat_enable      <= 1'b0;
         cfg_ff.long_press_enable      <= 1'b0;
         cfg_ff.debounce_ticks         <= bpq_pkg::DEBOUNCE_TICKS_RESET;
         cfg_ff.long_ticks             <= bpq_pkg::LONG_TICKS_RESET;
         cfg_ff.repeat_interval_first  <= bpq_pkg::REPEAT_INTERVAL_FIRST_RESET;
         cfg_ff.repeat_interval_second <= bpq_pkg::REPEAT_INTERVAL_SECOND_RESET;
         cfg_ff.repeat_interval_third  <= bpq_pkg::REPEAT_INTERVAL_THIRD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/bpq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press qualifier engine
// Hold, repeat and count state with the per-word update and flag logic.
// ----------------------------------------------------------------------------
module bpq_engine #(
   parameter int          COUNT_WIDTH     = bpq_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned REPEAT_STEP_ONE = bpq_pkg::REPEAT_STEP_ONE_DEFAULT,
   parameter int unsigned REPEAT_STEP_TWO = bpq_pkg::REPEAT_STEP_TWO_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bpq_pkg::cfg_type               cfg,
   input  logic                           fire,
   input  logic [bpq_pkg::MODE_WIDTH-1:0] mode,
   input  logic                           level,
   output logic                           short_press,
   output logic                           long_press
);

   // Compares run at the wider of the counter and register widths.
   localparam int CMP_WIDTH = (COUNT_WIDTH > bpq_pkg::CFG_WIDTH) ?
                              COUNT_WIDTH : bpq_pkg::CFG_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] hold_ff,   hold_in;
   logic [COUNT_WIDTH-1:0] rep_ff,    rep_in;
   logic [COUNT_WIDTH-1:0] count_ff,  count_in;
   logic                   short_ff,  short_in;
   logic                   long_ff,   long_in;

   logic [COUNT_WIDTH-1:0]         hold_inc;
   logic [COUNT_WIDTH-1:0]         rep_base;
   logic [COUNT_WIDTH-1:0]         rep_inc;
   logic [COUNT_WIDTH-1:0]         count_inc;
   logic [bpq_pkg::CFG_WIDTH-1:0]  interval;
   logic                           long_event;
   logic                           repeating;
   logic                           repeat_hit;
   logic                           released_short;
   logic                           tick_short;
   logic                           tick_long;

   always_comb begin
      hold_inc  = (hold_ff == CNT_MAX) ? hold_ff : hold_ff + 1'b1;
      // The long event fires only when the counter really moves onto the threshold.
      long_event = cfg.long_press_enable && (hold_ff != CNT_MAX) &&
                   (CMP_WIDTH'(hold_inc) == CMP_WIDTH'(cfg.long_ticks));
      rep_base  = long_event ? '0 : rep_ff;
      rep_inc   = (rep_base == CNT_MAX) ? rep_base : rep_base + 1'b1;
      count_inc = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
      repeating = cfg.autorepeat_enable &&
                  (CMP_WIDTH'(hold_inc) >= CMP_WIDTH'(cfg.long_ticks));

      if (32'(count_ff) > REPEAT_STEP_TWO) begin
         interval = cfg.repeat_interval_third;
      end else if (32'(count_ff) > REPEAT_STEP_ONE) begin
         interval = cfg.repeat_interval_second;
      end else begin
         interval = cfg.repeat_interval_first;
      end
      repeat_hit = repeating && (CMP_WIDTH'(rep_inc) >= CMP_WIDTH'(interval));

      released_short = (CMP_WIDTH'(hold_ff) >= CMP_WIDTH'(cfg.debounce_ticks)) &&
                       (CMP_WIDTH'(hold_ff) <  CMP_WIDTH'(cfg.long_ticks));

      tick_short = level ? (short_ff | repeat_hit) : released_short;
      tick_long  = level ? (long_ff | long_event) : 1'b0;

      hold_in     = hold_ff;
      rep_in      = rep_ff;
      count_in    = count_ff;
      short_in    = short_ff;
      long_in     = long_ff;
      short_press = short_ff;
      long_press  = long_ff;

      case (mode)
         bpq_pkg::MODE_TICK: begin
            short_press = tick_short;
            long_press  = tick_long;
            short_in    = tick_short;
            long_in     = tick_long;
            if (level) begin
               hold_in = hold_inc;
               if (repeat_hit) begin
                  rep_in   = '0;
                  count_in = count_inc;
               end else if (repeating) begin
                  rep_in = rep_inc;
               end else begin
                  rep_in = rep_base;
               end
            end else begin
               hold_in  = '0;
               rep_in   = '0;
               count_in = '0;
            end
         end
         bpq_pkg::MODE_READ_SHORT: short_in = 1'b0;
         bpq_pkg::MODE_READ_LONG:  long_in  = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         rep_ff   <= '0;
         count_ff <= '0;
         short_ff <= 1'b0;
         long_ff  <= 1'b0;
      end else if (fire) begin
         hold_ff  <= hold_in;
         rep_ff   <= rep_in;
         count_ff <= count_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      fire && mode == bpq_pkg::MODE_TICK && !level
      |=> hold_ff == '0 && rep_ff == '0 && count_ff == '0 && !long_ff)
      else $error("release did not clear counters and long flag");

   a_read_short_clears: assert property (@(posedge clock) disable iff (reset)
      fire && mode == bpq_pkg::MODE_READ_SHORT |=> !short_ff)
      else $error("short flag survived its read");

   a_long_needs_enable: assert property (@(posedge clock) disable iff (reset)
      $rose(long_ff) |-> $past(fire) && $past(cfg.long_press_enable))
      else $error("long flag set without long press enabled");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(hold_ff) && $stable(count_ff) && $stable(short_ff))
      else $error("state changed without a word");

endmodule

// File: sv/button_press_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press qualifier
// Debounce, long press and autorepeat qualifier driven by tick and read words.
// ----------------------------------------------------------------------------
// The block accepts one word per clock cycle while the result is not stalled
// and returns exactly one result word for each, after it passes through the
// input register and then the result register. The rate is set by the update
// of the hold, repeat and count registers, which each word reads and writes.
// A stalled result stops the pipeline, while the input register still takes
// one more word. Configuration writes are always accepted and should be made
// while no word is in flight.
module button_press_qualifier #(
   parameter int          COUNT_WIDTH     = bpq_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned REPEAT_STEP_ONE = bpq_pkg::REPEAT_STEP_ONE_DEFAULT,
   parameter int unsigned REPEAT_STEP_TWO = bpq_pkg::REPEAT_STEP_TWO_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bpq_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // [0] pin_level
   input  logic [bpq_pkg::MODE_WIDTH-1:0]      req_tuser,  // [1:0] mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bpq_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,  // [0] short_press, [1] long_press
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bpq_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   bpq_pkg::cfg_type cfg;

   logic                           in_valid_ff, in_valid_in;
   logic [bpq_pkg::MODE_WIDTH-1:0] in_mode_ff;
   logic                           in_level_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_flags_ff;
   logic                           advance;
   logic                           fire;
   logic                           req_fire;
   logic                           short_press;
   logic                           long_press;

   assign csr_ready = 1'b1;

   bpq_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign fire       = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   bpq_engine #(
      .COUNT_WIDTH     (COUNT_WIDTH),
      .REPEAT_STEP_ONE (REPEAT_STEP_ONE),
      .REPEAT_STEP_TWO (REPEAT_STEP_TWO)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .fire        (fire),
      .mode        (in_mode_ff),
      .level       (in_level_ff),
      .short_press (short_press),
      .long_press  (long_press)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff  <= req_tuser;
         in_level_ff <= req_tdata[0];
      end
      if (fire) begin
         rsp_flags_ff <= {long_press, short_press};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bpq_pkg::RSP_DATA_WIDTH - 2){1'b0}}, rsp_flags_ff};

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

   a_fire_makes_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word produced no result");

   a_result_kept_until_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !fire)
      else $error("pending result overwritten");

endmodule
